### design/ple_pkg.sv
package ple_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;

    localparam logic [FUNC_W-1:0] FN_INS_HEAD = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_TAIL = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_POS  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_HEAD = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_TAIL = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DEL_POS  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_DUMP     = 3'd6;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } t_cell_op;

    // Broadcast to every cell of the row.
    typedef struct packed {
        t_cell_op                op;
        logic [POS_W-1:0]        idx;   // target slot for insert / delete
        logic [POS_W-1:0]        tail;  // slot of the last element, for rotate
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

### design/ple_cell.sv
module ple_cell #(
    parameter int IDX = 0
) (
    input  logic                                i_clk,
    input  ple_pkg::t_cell_ctl                  i_ctl,
    input  logic signed [ple_pkg::DATA_W-1:0]   i_left,
    input  logic signed [ple_pkg::DATA_W-1:0]   i_right,
    input  logic signed [ple_pkg::DATA_W-1:0]   i_head,
    output logic signed [ple_pkg::DATA_W-1:0]   o_value
);

    localparam logic [ple_pkg::POS_W-1:0] MY_IDX = ple_pkg::POS_W'(IDX);

    logic signed [ple_pkg::DATA_W-1:0] r_value;
    logic signed [ple_pkg::DATA_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        case (i_ctl.op)
            ple_pkg::CELL_INS: begin
                // take the new value at the slot, shift right above it
                if (MY_IDX == i_ctl.idx) begin
                    n_value = i_ctl.value;
                end else if (MY_IDX > i_ctl.idx) begin
                    n_value = i_left;
                end
            end
            ple_pkg::CELL_DEL: begin
                if (MY_IDX >= i_ctl.idx) begin
                    n_value = i_right;
                end
            end
            ple_pkg::CELL_ROT: begin
                // advance toward the head, the head wraps to the tail slot
                if (MY_IDX < i_ctl.tail) begin
                    n_value = i_right;
                end else if (MY_IDX == i_ctl.tail) begin
                    n_value = i_head;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

### design/positional_list_engine.sv
// Channel   Dir  Payload
// s_axis    in   tdata = value[31:0], position[39:32]; tuser = func[2:0]
// m_axis    out  tdata = status[1:0], count[6:2], element[38:7], pad[39];
//                tuser = element_valid; tlast = last beat of this item
//
// Operations: every insert or delete acts on all cells of the row in
// parallel. A dump holds off the input until every stored element (up
// to CAPACITY) has gone out: the row rotates by one slot a beat and the
// head cell feeds the output register, so the list is back in order at
// the end.
// Reset (i_rst_n low, synchronous) empties the list; cell contents are
// not cleared. A stalled m_axis holds the output register and the dump.
module positional_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], position[39:32]
    input  logic [2:0]  s_axis_tuser,   // func[2:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status[1:0], count[6:2], element[38:7]
    output logic        m_axis_tuser,   // element_valid
    output logic        m_axis_tlast
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int DW = ple_pkg::DATA_W;
    localparam int PW = ple_pkg::POS_W;

    // Row of cells
    ple_pkg::t_cell_ctl       w_ctl;
    logic signed [DW-1:0]     w_val [CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [DW-1:0] w_left;
            logic signed [DW-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_val[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_val[g+1];
            end
            ple_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_left  (w_left),
                .i_right (w_right),
                .i_head  (w_val[0]),
                .o_value (w_val[g])
            );
        end
    endgenerate

    // Control state
    ple_pkg::t_state r_state, n_state;
    logic [LW-1:0]   r_len, n_len;
    logic [LW-1:0]   r_dump_idx, n_dump_idx;

    // Output register
    logic                           r_m_valid;
    logic [ple_pkg::STAT_W-1:0]     r_m_status, n_m_status;
    logic [ple_pkg::CNT_W-1:0]      r_m_count,  n_m_count;
    logic signed [DW-1:0]           r_m_elem,   n_m_elem;
    logic                           r_m_evalid, n_m_evalid;
    logic                           r_m_last,   n_m_last;
    logic                           w_load;

    // Input unpacking
    logic [ple_pkg::FUNC_W-1:0] w_func;
    logic signed [DW-1:0]       w_value;
    logic [PW-1:0]              w_pos;
    logic [PW-1:0]              w_pos_ins;
    logic [PW-1:0]              w_len8;
    logic                       w_full;
    logic                       w_empty;
    logic                       w_out_free;
    logic                       w_accept;

    assign w_func     = s_axis_tuser;
    assign w_value    = s_axis_tdata[31:0];
    assign w_pos      = s_axis_tdata[39:32];
    assign w_pos_ins  = (w_pos == '0) ? PW'(1) : w_pos;   // treat position 0 as 1
    assign w_len8     = PW'(r_len);
    assign w_full     = (r_len == LW'(CAPACITY));
    assign w_empty    = (r_len == '0);
    assign w_out_free = !r_m_valid || m_axis_tready;

    // Take a new beat only between dumps and when the output register frees up
    assign s_axis_tready = (r_state == ple_pkg::ST_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state       = r_state;
        n_len         = r_len;
        n_dump_idx    = r_dump_idx;
        w_load        = 1'b0;
        w_ctl.op      = ple_pkg::CELL_HOLD;
        w_ctl.idx     = '0;
        w_ctl.tail    = w_len8 - PW'(1);
        w_ctl.value   = w_value;
        n_m_status    = ple_pkg::STAT_OK;
        n_m_elem      = '0;
        n_m_evalid    = 1'b0;
        n_m_last      = 1'b1;

        case (r_state)
            ple_pkg::ST_IDLE: begin
                if (w_accept) begin
                    w_load = 1'b1;
                    case (w_func)
                        ple_pkg::FN_INS_HEAD,
                        ple_pkg::FN_INS_TAIL,
                        ple_pkg::FN_INS_POS: begin
                            if (w_full) begin
                                // drop the insert
                                n_m_status = ple_pkg::STAT_FULL;
                            end else begin
                                w_ctl.op = ple_pkg::CELL_INS;
                                n_len    = r_len + LW'(1);
                                if (w_func == ple_pkg::FN_INS_HEAD || w_empty) begin
                                    w_ctl.idx = '0;
                                end else if (w_func == ple_pkg::FN_INS_TAIL) begin
                                    w_ctl.idx = w_len8;
                                end else if (w_pos_ins > w_len8) begin
                                    // past the end: append, flag the position
                                    w_ctl.idx  = w_len8;
                                    n_m_status = ple_pkg::STAT_BADPOS;
                                end else begin
                                    w_ctl.idx = w_pos_ins;
                                end
                            end
                        end
                        ple_pkg::FN_DEL_HEAD,
                        ple_pkg::FN_DEL_TAIL,
                        ple_pkg::FN_DEL_POS: begin
                            if (w_empty) begin
                                n_m_status = ple_pkg::STAT_EMPTY;
                            end else if (w_func == ple_pkg::FN_DEL_POS && w_pos > w_len8) begin
                                n_m_status = ple_pkg::STAT_BADPOS;
                            end else begin
                                w_ctl.op = ple_pkg::CELL_DEL;
                                n_len    = r_len - LW'(1);
                                if (w_func == ple_pkg::FN_DEL_HEAD) begin
                                    w_ctl.idx = '0;
                                end else if (w_func == ple_pkg::FN_DEL_TAIL) begin
                                    w_ctl.idx = w_len8 - PW'(1);
                                end else if (w_pos <= PW'(1)) begin
                                    // position one or below removes the head
                                    w_ctl.idx = '0;
                                end else begin
                                    w_ctl.idx = w_pos - PW'(1);
                                end
                            end
                        end
                        ple_pkg::FN_DUMP: begin
                            if (w_empty) begin
                                n_m_status = ple_pkg::STAT_EMPTY;
                            end else begin
                                // no beat yet; the dump state sends them
                                w_load     = 1'b0;
                                n_dump_idx = '0;
                                n_state    = ple_pkg::ST_DUMP;
                            end
                        end
                        default: begin
                            n_m_status = ple_pkg::STAT_BADPOS;
                        end
                    endcase
                end
            end
            ple_pkg::ST_DUMP: begin
                if (w_out_free) begin
                    // emit the head, rotate the row by one slot
                    w_load     = 1'b1;
                    w_ctl.op   = ple_pkg::CELL_ROT;
                    n_m_elem   = w_val[0];
                    n_m_evalid = 1'b1;
                    n_m_last   = (r_dump_idx == r_len - LW'(1));
                    n_dump_idx = r_dump_idx + LW'(1);
                    if (n_m_last) begin
                        n_state = ple_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ple_pkg::ST_IDLE;
            end
        endcase

        n_m_count = ple_pkg::CNT_W'(n_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ple_pkg::ST_IDLE;
            r_len      <= '0;
            r_dump_idx <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_dump_idx <= n_dump_idx;
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Output payload, held while the beat stalls
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_m_status <= n_m_status;
            r_m_count  <= n_m_count;
            r_m_elem   <= n_m_elem;
            r_m_evalid <= n_m_evalid;
            r_m_last   <= n_m_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {1'b0, r_m_elem, r_m_count, r_m_status};
    assign m_axis_tuser  = r_m_evalid;
    assign m_axis_tlast  = r_m_last;

endmodule

### tb/sv/positional_list_engine_tb.sv
`timescale 1ns / 1ps

module positional_list_engine_tb;

    localparam int LIST_CAP = 16;
    // Selector outside the defined operation set; the block must answer it
    // with a bad-position status and leave the list alone.
    localparam logic [ple_pkg::FUNC_W-1:0] FN_UNUSED = 3'd7;

    // One output beat as the block should present it.
    typedef struct {
        logic [ple_pkg::STAT_W-1:0] status;
        logic [ple_pkg::CNT_W-1:0]  count;
        logic [ple_pkg::DATA_W-1:0] element;
        logic                       element_valid;
        logic                       last;
    } t_list_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;    // value[31:0], position[39:32]
    logic [2:0]  s_axis_tuser = '0;    // func[2:0]

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // status[1:0], count[6:2], element[38:7], pad[39]
    logic        m_axis_tuser;         // element_valid
    logic        m_axis_tlast;

    // Shadow copy of the list, front of the queue is the head.
    logic signed [ple_pkg::DATA_W-1:0] list_model[$];
    t_list_beat                        expected_beats[$];

    int mismatch_count = 0;
    int beats_checked  = 0;
    int ops_accepted   = 0;
    int full_drops     = 0;
    int dump_beats     = 0;

    // Sender pacing: bursts of random length, random gaps between them.
    int burst_left = 0;
    bit no_idle    = 1'b0;

    // Receiver: long hold-off request handed over by the test tasks.
    int hold_req  = 0;
    int hold_left = 0;
    int rx_cycle  = 0;
    int rx_mode   = 0;

    positional_list_engine #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Record one beat that the list should produce, with the current length.
    function automatic void queue_beat(input logic [ple_pkg::STAT_W-1:0] st,
                                       input logic [ple_pkg::DATA_W-1:0] elem,
                                       input logic vld, input logic lst);
        t_list_beat b;
        b.status        = st;
        b.count         = ple_pkg::CNT_W'(list_model.size());
        b.element       = elem;
        b.element_valid = vld;
        b.last          = lst;
        expected_beats.push_back(b);
        if (st == ple_pkg::STAT_FULL) full_drops++;
        if (vld) dump_beats++;
    endfunction

    // Apply one accepted operation to the shadow list and queue its beats.
    task automatic predict_list_op(input logic [ple_pkg::FUNC_W-1:0] fn,
                                   input logic signed [ple_pkg::DATA_W-1:0] val,
                                   input logic [ple_pkg::POS_W-1:0] pos);
        logic [ple_pkg::STAT_W-1:0] st;
        int p;
        int n;
        st = ple_pkg::STAT_OK;
        p  = int'(pos);
        n  = list_model.size();
        case (fn)
            ple_pkg::FN_INS_HEAD, ple_pkg::FN_INS_TAIL, ple_pkg::FN_INS_POS: begin
                if (n >= LIST_CAP) begin
                    st = ple_pkg::STAT_FULL;
                end else if (fn == ple_pkg::FN_INS_HEAD || n == 0) begin
                    list_model.push_front(val);
                end else if (fn == ple_pkg::FN_INS_TAIL) begin
                    list_model.push_back(val);
                end else begin
                    // Insert after position p; p of zero counts as one.
                    if (p < 1) p = 1;
                    if (p > n) begin
                        list_model.push_back(val);
                        st = ple_pkg::STAT_BADPOS;
                    end else begin
                        list_model.insert(p, val);
                    end
                end
            end
            ple_pkg::FN_DEL_HEAD, ple_pkg::FN_DEL_TAIL, ple_pkg::FN_DEL_POS: begin
                if (n == 0) begin
                    st = ple_pkg::STAT_EMPTY;
                end else if (fn == ple_pkg::FN_DEL_HEAD) begin
                    void'(list_model.pop_front());
                end else if (fn == ple_pkg::FN_DEL_TAIL) begin
                    void'(list_model.pop_back());
                end else if (p > n) begin
                    st = ple_pkg::STAT_BADPOS;
                end else begin
                    list_model.delete((p <= 1) ? 0 : p - 1);
                end
            end
            ple_pkg::FN_DUMP: begin
                // Dump gives its own beats; nothing more after the loop.
                if (n == 0) begin
                    queue_beat(ple_pkg::STAT_EMPTY, '0, 1'b0, 1'b1);
                end else begin
                    for (int i = 0; i < n; i++)
                        queue_beat(ple_pkg::STAT_OK, list_model[i], 1'b1, i == n - 1);
                end
            end
            default: st = ple_pkg::STAT_BADPOS;
        endcase
        if (fn != ple_pkg::FN_DUMP) queue_beat(st, '0, 1'b0, 1'b1);
    endtask

    // Watch both channels at the rising edge. Check the output beat before
    // predicting from the input beat of the same edge: a result can never
    // leave in the cycle that its operation is accepted.
    always @(posedge i_clk) begin : beat_monitor
        t_list_beat exp_b;
        t_list_beat got_b;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_b.status        = m_axis_tdata[1:0];
            got_b.count         = m_axis_tdata[6:2];
            got_b.element       = m_axis_tdata[38:7];
            got_b.element_valid = m_axis_tuser;
            got_b.last          = m_axis_tlast;
            beats_checked++;
            if (expected_beats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected beat st=%0d cnt=%0d elem=%h ev=%b last=%b",
                             $realtime, got_b.status, got_b.count, got_b.element,
                             got_b.element_valid, got_b.last);
            end else begin
                exp_b = expected_beats.pop_front();
                if (got_b.status !== exp_b.status || got_b.count !== exp_b.count ||
                    got_b.element !== exp_b.element ||
                    got_b.element_valid !== exp_b.element_valid ||
                    got_b.last !== exp_b.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: beat mismatch exp st=%0d cnt=%0d elem=%h ev=%b last=%b",
                                 $realtime, exp_b.status, exp_b.count, exp_b.element,
                                 exp_b.element_valid, exp_b.last);
                        $display("    got st=%0d cnt=%0d elem=%h ev=%b last=%b",
                                 got_b.status, got_b.count, got_b.element,
                                 got_b.element_valid, got_b.last);
                    end
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            ops_accepted++;
            predict_list_op(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[39:32]);
        end
    end

    // Receiver: switch among random stall patterns; a pending hold-off
    // request overrides the pattern until its cycle count runs out.
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (rx_cycle % 48 == 0) rx_mode = int'($urandom_range(0, 3));
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_axis_tready <= 1'b1;                       // no stalls at all
                1: m_axis_tready <= ($urandom_range(0, 9) < 7); // scattered stalls
                2: m_axis_tready <= (rx_cycle % 3 == 0);        // periodic stalls
                default: m_axis_tready <= (rx_cycle[3:2] != 2'b11); // stall blocks
            endcase
        end
    end

    // Offer one operation and hold it until the block takes it, then pace.
    task automatic send_op(input logic [ple_pkg::FUNC_W-1:0] fn,
                           input logic [ple_pkg::DATA_W-1:0] val,
                           input logic [ple_pkg::POS_W-1:0] pos);
        int gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pos, val};
        s_axis_tuser  <= fn;
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = int'($urandom_range(0, 12));
            gap = no_idle ? 0 : int'($urandom_range(0, 7));
            if (gap > 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    // Drop valid and hold off until every expected beat has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Empty-list handling, every selector, position clamping, bad positions
    // and the head/tail edge cases of a short list.
    task automatic test_edge_cases();
        send_op(ple_pkg::FN_DUMP,     32'h0,         8'd0);    // dump of an empty list
        send_op(ple_pkg::FN_DEL_HEAD, 32'h1234_5678, 8'd0);    // deletes on empty list
        send_op(ple_pkg::FN_DEL_TAIL, 32'h0,         8'd0);
        send_op(ple_pkg::FN_DEL_POS,  32'h0,         8'd3);
        send_op(ple_pkg::FN_INS_POS,  32'h0000_0001, 8'd9);    // positional insert, empty
        send_op(ple_pkg::FN_INS_HEAD, 32'h7FFF_FFFF, 8'd255);
        send_op(ple_pkg::FN_INS_TAIL, 32'h8000_0000, 8'd0);
        send_op(ple_pkg::FN_INS_POS,  32'hFFFF_FFFF, 8'd0);    // position zero acts as one
        send_op(ple_pkg::FN_INS_POS,  32'h0000_0000, 8'd255);  // beyond length, at tail
        send_op(FN_UNUSED,            32'hDEAD_BEEF, 8'd1);
        send_op(ple_pkg::FN_DUMP,     32'h0,         8'd0);
        send_op(ple_pkg::FN_DEL_POS,  32'h0,         8'd0);    // delete at zero takes head
        send_op(ple_pkg::FN_DEL_POS,  32'h0,         8'd1);
        send_op(ple_pkg::FN_DEL_POS,  32'h0,         8'd200);  // delete beyond length
        send_op(ple_pkg::FN_DEL_POS,  32'h0,         8'd2);
        send_op(ple_pkg::FN_DEL_TAIL, 32'h0,         8'd0);
        send_op(ple_pkg::FN_DEL_TAIL, 32'h0,         8'd0);    // tail delete of last element
        send_op(ple_pkg::FN_DUMP,     32'h0,         8'd0);
        send_op(ple_pkg::FN_INS_TAIL, 32'h5555_5555, 8'hAA);   // tail insert into empty list
        send_op(ple_pkg::FN_INS_POS,  32'hAAAA_AAAA, 8'h55);
        send_op(ple_pkg::FN_DUMP,     32'h0,         8'd0);
        wait_drained();
    endtask

    // Hold the receiver off while the sender streams inserts with no gaps:
    // fill the list, overflow it with every insert kind, dump it whole, then
    // send it more deletes of every kind than it holds.
    task automatic test_full_list_backpressure();
        logic [ple_pkg::FUNC_W-1:0] fn;
        @(posedge i_clk);
        hold_req = 180;
        no_idle  = 1'b1;
        for (int i = 0; i < LIST_CAP + 2; i++) begin
            case (i % 3)
                0: fn = ple_pkg::FN_INS_HEAD;
                1: fn = ple_pkg::FN_INS_TAIL;
                default: fn = ple_pkg::FN_INS_POS;
            endcase
            send_op(fn, $urandom, ple_pkg::POS_W'($urandom_range(0, 20)));
        end
        send_op(ple_pkg::FN_INS_HEAD, $urandom, 8'd0);
        send_op(ple_pkg::FN_INS_TAIL, $urandom, 8'd0);
        send_op(ple_pkg::FN_INS_POS,  $urandom, 8'd5);
        send_op(ple_pkg::FN_DUMP,     32'h0,    8'd0);
        for (int i = 0; i < LIST_CAP + 2; i++) begin
            case (i % 3)
                0: fn = ple_pkg::FN_DEL_HEAD;
                1: fn = ple_pkg::FN_DEL_TAIL;
                default: fn = ple_pkg::FN_DEL_POS;
            endcase
            send_op(fn, $urandom, ple_pkg::POS_W'($urandom_range(0, 17)));
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    // Random operations, alternating between a filling bias and a draining
    // bias so the list length sweeps from empty to full and back.
    task automatic test_random_ops(input int n_ops);
        logic [ple_pkg::FUNC_W-1:0] fn;
        logic [ple_pkg::POS_W-1:0]  pos;
        int r;
        bit filling;
        for (int i = 0; i < n_ops; i++) begin
            if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            filling = ((i / 40) % 2 == 0);
            r = int'($urandom_range(0, 99));
            if (filling) begin
                if      (r < 25) fn = ple_pkg::FN_INS_HEAD;
                else if (r < 50) fn = ple_pkg::FN_INS_TAIL;
                else if (r < 75) fn = ple_pkg::FN_INS_POS;
                else if (r < 82) fn = ple_pkg::FN_DEL_HEAD;
                else if (r < 88) fn = ple_pkg::FN_DEL_TAIL;
                else if (r < 93) fn = ple_pkg::FN_DEL_POS;
                else if (r < 98) fn = ple_pkg::FN_DUMP;
                else             fn = FN_UNUSED;
            end else begin
                if      (r < 8)  fn = ple_pkg::FN_INS_HEAD;
                else if (r < 16) fn = ple_pkg::FN_INS_TAIL;
                else if (r < 24) fn = ple_pkg::FN_INS_POS;
                else if (r < 44) fn = ple_pkg::FN_DEL_HEAD;
                else if (r < 64) fn = ple_pkg::FN_DEL_TAIL;
                else if (r < 86) fn = ple_pkg::FN_DEL_POS;
                else if (r < 96) fn = ple_pkg::FN_DUMP;
                else             fn = FN_UNUSED;
            end
            // Mostly positions around the live length, sometimes anything.
            if ($urandom_range(0, 3) != 0) begin
                pos = ple_pkg::POS_W'($urandom_range(0, 18));
            end else begin
                pos = ple_pkg::POS_W'($urandom_range(0, 255));
            end
            send_op(fn, $urandom, pos);
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_edge_cases();
        test_full_list_backpressure();
        test_random_ops(210);

        repeat (20) @(posedge i_clk);
        $display("Covered %0d list operations and %0d result beats (%0d dumped elements,",
                 ops_accepted, beats_checked, dump_beats);
        $display("  %0d full-list drops), with random gaps, stalls and a long hold-off.",
                 full_drops);
        if (mismatch_count == 0 && expected_beats.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d beats still pending", mismatch_count,
                     expected_beats.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    // Bound the run well above the slowest correct run.
    initial begin
        #4000000;
        $display("Timeout with %0d beats still pending", expected_beats.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
